>>> rtl/kdft_pkg.sv
// Shared types and constants for the drag and fling tracker.
// Used by the front queue, the divider, the back sequencer and the top level.
// No dependencies.
`default_nettype none

package kdft_pkg;

   // event kinds as carried in the input tuser
   typedef enum logic [1:0] {
      KIND_PRESS   = 2'd0,
      KIND_MOVE    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   // gesture mode as reported on the result channel
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_DRAG  = 2'd1,
      MODE_FLING = 2'd2
   } mode_type;

   // register indexes on the csr channel
   localparam logic [7:0] CSR_TAP_THR = 8'd0;
   localparam logic [7:0] CSR_DECEL   = 8'd1;

   localparam logic [23:0] TAP_THR_RESET = 24'd57;
   localparam logic [19:0] DECEL_RESET   = 20'd1049;
   // stop speed, 0.001 px/ms in 2^-20 px/ms
   localparam logic [19:0] STOP_SPEED    = 20'd1049;

   // divider dividend width: magnitude << 24 for a 2^31 speed
   localparam int QW     = 56;
   localparam int DIST_W = 39;

   // one queued event after classification
   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [31:0]        time_ms;
   } item_type;

   // one result beat
   typedef struct packed {
      logic [31:0] dx;
      logic [31:0] dy;
      logic        step;
      logic        gstart;
      logic        tap;
      logic        fstop;
      mode_type    mode;
   } res_type;

   typedef struct packed {
      logic          start;
      logic [QW-1:0] dividend;
      logic [31:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic          done;
      logic [QW-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> rtl/kinetic_drag_fling_tracker.sv
// Pointer drag and fling tracker, top level.
// Event beats enter on req_*: tuser carries the kind (press, move, release,
// frame tick), tdata the position and time. Each accepted beat gives exactly
// one result beat on rsp_*: scroll distance in tdata, flags and mode in tuser.
// Registers (csr_* index 0 tap threshold, 1 deceleration) are to be written
// only while no event is in flight (unenforced); csr_ready is always high.
// Press, move and ignored events go straight to the output stage; a
// release that is no tap is bound by two passes of the shared
// one-bit-per-cycle divider. A frame tick during a fling runs a 32-step
// square root plus two divider passes; a tick that ends the fling stops
// after the square root.
// Events are handled one at a time; a two-entry queue in front takes new
// beats while one is being worked on, and a result register lets the next
// event start while the receiver stalls rsp_tready.
// Synchronous reset returns to idle with default registers and empties the
// queue and the result register.
// Depends on kdft_pkg, kdft_front, kdft_div and kdft_back.
`default_nettype none

module kinetic_drag_fling_tracker #(
   parameter int SPEED_FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // pos_x[15:0], pos_y[31:16], time_ms[63:32]
   input  wire  [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // scroll_dx[31:0], scroll_dy[63:32]
   output logic [5:0]  rsp_tuser,   // step_valid[0], gesture_start[1], tap_press[2],
                                    // fling_stop[3], mode_now[5:4]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_index,
   input  wire  [23:0] csr_data
);

   logic                   q_valid;
   logic                   q_ready;
   kdft_pkg::item_type     q_item;
   kdft_pkg::div_req_type  div_req;
   kdft_pkg::div_rsp_type  div_rsp;
   kdft_pkg::res_type      rsp_res;

   kdft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   kdft_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   kdft_back #(
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (rsp_res)
   );

   // pack the result beat
   assign rsp_tdata = {rsp_res.dy, rsp_res.dx};
   assign rsp_tuser = {rsp_res.mode, rsp_res.fstop, rsp_res.tap,
                       rsp_res.gstart, rsp_res.step};

endmodule

`default_nettype wire

>>> rtl/kdft_front.sv
// Input side: takes event beats, classifies them and queues them.
// Depends on kdft_pkg.
`default_nettype none

module kdft_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [63:0]          req_tdata,   // pos_x[15:0], pos_y[31:16], time_ms[63:32]
   input  wire  [1:0]           req_tuser,   // func[1:0]
   output logic                 q_valid,
   input  wire                  q_ready,
   output kdft_pkg::item_type   q_item
);

   kdft_pkg::item_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   kdft_pkg::item_type item;
   logic               push, pop;

   // classify the incoming beat
   always_comb begin
      item.kind    = kdft_pkg::kind_type'(req_tuser[1:0]);
      item.pos_x   = req_tdata[15:0];
      item.pos_y   = req_tdata[31:16];
      item.time_ms = req_tdata[63:32];
   end

   assign req_tready = (count_ff != 2'd2);
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = mem_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = q_valid & q_ready;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/kdft_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on kdft_pkg.
`default_nettype none

module kdft_div (
   input  wire                    clock,
   input  wire                    reset,
   input  kdft_pkg::div_req_type  div_req,
   output kdft_pkg::div_rsp_type  div_rsp
);

   localparam int QW   = kdft_pkg::QW;
   localparam int CNTW = $clog2(QW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [31:0]     rem_ff, rem_in;
   logic [QW-1:0]   dvd_ff, dvd_in;
   logic [31:0]     dsr_ff, dsr_in;
   logic [32:0]     rem_sh;
   logic            fits;

   assign rem_sh = {rem_ff, dvd_ff[QW-1]};
   assign fits   = (rem_sh >= {1'b0, dsr_ff});

   // one shift-subtract step a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 32'(rem_sh - {1'b0, dsr_ff}) : rem_sh[31:0];
         dvd_in = {dvd_ff[QW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

`default_nettype wire

>>> rtl/kdft_back.sv
// Back side: gesture state, config registers and the sequencer that runs
// release and frame tick events through squares, square root and shared divider.
// Depends on kdft_pkg; drives kdft_div through div_req/div_rsp.
`default_nettype none

module kdft_back #(
   parameter int SPEED_FRAC_BITS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_valid,
   output logic                   q_ready,
   input  kdft_pkg::item_type     q_item,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [7:0]             csr_index,
   input  wire  [23:0]            csr_data,
   output kdft_pkg::div_req_type  div_req,
   input  kdft_pkg::div_rsp_type  div_rsp,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output kdft_pkg::res_type      rsp_res
);

   localparam int F  = SPEED_FRAC_BITS;
   localparam int K  = F + 13;
   localparam int CW = 53 + F;
   localparam int QW = kdft_pkg::QW;
   localparam int DW = kdft_pkg::DIST_W;

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_RSQ   = 15'b000000000000010,
      S_RCMP  = 15'b000000000000100,
      S_RDIVX = 15'b000000000001000,
      S_RDIVY = 15'b000000000010000,
      S_TMUL  = 15'b000000000100000,
      S_TSUM  = 15'b000000001000000,
      S_TSQRT = 15'b000000010000000,
      S_TCHK  = 15'b000000100000000,
      S_TVMUL = 15'b000001000000000,
      S_TDIST = 15'b000010000000000,
      S_TDIVX = 15'b000100000000000,
      S_TDIVY = 15'b001000000000000,
      S_TCMUL = 15'b010000000000000,
      S_OUT   = 15'b100000000000000
   } state_type;

   state_type            state_ff, state_in;
   kdft_pkg::mode_type   mode_ff, mode_in;
   logic signed [15:0]   press_x_ff, press_x_in, press_y_ff, press_y_in;
   logic [31:0]          press_time_ff, press_time_in;
   logic [31:0]          speed_x_ff, speed_x_in, speed_y_ff, speed_y_in;
   logic [23:0]          thr_ff, thr_in;
   logic [19:0]          decel_ff, decel_in;

   logic signed [16:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]          t_ff, t_in;
   logic [31:0]          mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [63:0]          sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [51:0]          at_ff, at_in;
   logic [63:0]          rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [53:0]          v_ff, v_in;
   logic [53:0]          pa_ff, pa_in;
   logic [63:0]          pb_ff, pb_in;
   logic [DW-1:0]        d_ff, d_in;
   logic [24:0]          rx_ff, rx_in, ry_ff, ry_in;
   kdft_pkg::res_type    res_ff, res_in;
   kdft_pkg::res_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // datapath terms
   logic signed [33:0]   psq_x, psq_y;
   logic [34:0]          d2;
   logic [16:0]          adx, ady;
   logic [31:0]          dt;
   logic [63:0]          trial;
   logic [52:0]          atp;
   logic                 stop_lim, stop_cmp;
   logic [CW-1:0]        cmp_lhs, cmp_rhs;
   logic [51+F:0]        at_sh;
   logic [85:0]          prod, prod_sh;
   logic [63:0]          cx_full, cy_full;

   function automatic logic [31:0] sat_speed(input logic [QW-1:0] q, input logic neg);
      logic [30:0] m;
      m = (|q[QW-1:31]) ? 31'h7FFF_FFFF : q[30:0];
      return neg ? (32'd0 - {1'b0, m}) : {1'b0, m};
   endfunction

   function automatic logic [31:0] magnitude(input logic [31:0] u);
      return u[31] ? (32'd0 - u) : u;
   endfunction

   assign psq_x   = dx_ff * dx_ff;
   assign psq_y   = dy_ff * dy_ff;
   assign d2      = {1'b0, sq_x_ff[33:0]} + {1'b0, sq_y_ff[33:0]};
   assign adx     = dx_ff[16] ? 17'(-dx_ff) : 17'(dx_ff);
   assign ady     = dy_ff[16] ? 17'(-dy_ff) : 17'(dy_ff);
   assign dt      = (t_ff == 32'd0) ? 32'd1 : t_ff;
   assign trial   = root_ff + bit_ff;
   assign atp     = {1'b0, at_ff} + {33'd0, kdft_pkg::STOP_SPEED};
   assign stop_lim = |atp[52:52-F];
   assign cmp_lhs = {{(CW-52){1'b0}}, root_ff[31:0], 20'd0};
   assign cmp_rhs = {atp, {F{1'b0}}};
   assign stop_cmp = (cmp_lhs <= cmp_rhs);
   assign at_sh   = {at_ff, {F{1'b0}}};
   assign prod    = {pa_ff, 32'd0} + {22'd0, pb_ff};
   assign prod_sh = prod >> K;
   assign cx_full = {39'd0, rx_ff} * {25'd0, d_ff};
   assign cy_full = {39'd0, ry_ff} * {25'd0, d_ff};

   assign q_ready   = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      press_x_in    = press_x_ff;
      press_y_in    = press_y_ff;
      press_time_in = press_time_ff;
      speed_x_in    = speed_x_ff;
      speed_y_in    = speed_y_ff;
      thr_in        = thr_ff;
      decel_in      = decel_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      t_in          = t_ff;
      mag_x_in      = mag_x_ff;
      mag_y_in      = mag_y_ff;
      sq_x_in       = sq_x_ff;
      sq_y_in       = sq_y_ff;
      at_in         = at_ff;
      rad_in        = rad_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      v_in          = v_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      d_in          = d_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      div_req       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // config writes are to land only while idle, unenforced by the block
      if (csr_valid) begin
         if (csr_index == kdft_pkg::CSR_TAP_THR) begin
            thr_in = csr_data;
         end else if (csr_index == kdft_pkg::CSR_DECEL) begin
            decel_in = csr_data[19:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               res_in   = '0;
               state_in = S_OUT;
               unique case (q_item.kind)
                  kdft_pkg::KIND_PRESS: begin
                     res_in.gstart = 1'b1;
                     res_in.fstop  = (mode_ff == kdft_pkg::MODE_FLING);
                     mode_in       = kdft_pkg::MODE_DRAG;
                     press_x_in    = q_item.pos_x;
                     press_y_in    = q_item.pos_y;
                     press_time_in = q_item.time_ms;
                  end
                  kdft_pkg::KIND_MOVE: begin
                     if (mode_ff == kdft_pkg::MODE_DRAG) begin
                        res_in.dx   = {{16{press_x_ff[15]}}, press_x_ff}
                                    - {{16{q_item.pos_x[15]}}, q_item.pos_x};
                        res_in.dy   = {{16{press_y_ff[15]}}, press_y_ff}
                                    - {{16{q_item.pos_y[15]}}, q_item.pos_y};
                        res_in.step = 1'b1;
                     end
                  end
                  kdft_pkg::KIND_RELEASE: begin
                     if (mode_ff == kdft_pkg::MODE_DRAG) begin
                        dx_in    = {q_item.pos_x[15], q_item.pos_x}
                                 - {press_x_ff[15], press_x_ff};
                        dy_in    = {q_item.pos_y[15], q_item.pos_y}
                                 - {press_y_ff[15], press_y_ff};
                        t_in     = q_item.time_ms - press_time_ff;
                        state_in = S_RSQ;
                     end
                  end
                  kdft_pkg::KIND_TICK: begin
                     if (mode_ff == kdft_pkg::MODE_FLING) begin
                        mag_x_in = magnitude(speed_x_ff);
                        mag_y_in = magnitude(speed_y_ff);
                        t_in     = q_item.time_ms;
                        state_in = S_TMUL;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         // release: squared travel against the tap threshold
         S_RSQ: begin
            sq_x_in  = {30'd0, psq_x};
            sq_y_in  = {30'd0, psq_y};
            state_in = S_RCMP;
         end
         S_RCMP: begin
            if (d2 > {11'd0, thr_ff}) begin
               div_req.start    = 1'b1;
               div_req.dividend = {{(QW-17){1'b0}}, adx} << F;
               div_req.divisor  = dt;
               state_in         = S_RDIVX;
            end else begin
               mode_in    = kdft_pkg::MODE_IDLE;
               res_in.tap = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_RDIVX: begin
            if (div_rsp.done) begin
               speed_x_in       = sat_speed(div_rsp.quotient, dx_ff[16]);
               div_req.start    = 1'b1;
               div_req.dividend = {{(QW-17){1'b0}}, ady} << F;
               div_req.divisor  = dt;
               state_in         = S_RDIVY;
            end
         end
         S_RDIVY: begin
            if (div_rsp.done) begin
               speed_y_in    = sat_speed(div_rsp.quotient, dy_ff[16]);
               mode_in       = kdft_pkg::MODE_FLING;
               res_in.gstart = 1'b1;
               state_in      = S_OUT;
            end
         end
         // frame tick: speed magnitude and decay
         S_TMUL: begin
            sq_x_in  = {32'd0, mag_x_ff} * {32'd0, mag_x_ff};
            sq_y_in  = {32'd0, mag_y_ff} * {32'd0, mag_y_ff};
            at_in    = {32'd0, decel_ff} * {20'd0, t_ff};
            state_in = S_TSUM;
         end
         S_TSUM: begin
            rad_in   = sq_x_ff + sq_y_ff;
            root_in  = '0;
            bit_in   = 64'h4000_0000_0000_0000;
            state_in = S_TSQRT;
         end
         S_TSQRT: begin
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            if (stop_lim || stop_cmp) begin
               mode_in      = kdft_pkg::MODE_IDLE;
               res_in.fstop = 1'b1;
               state_in     = S_OUT;
            end else begin
               v_in     = {1'b0, root_ff[31:0], 21'd0} - at_sh[53:0];
               state_in = S_TVMUL;
            end
         end
         S_TVMUL: begin
            pa_in    = {22'd0, t_ff} * {32'd0, v_ff[53:32]};
            pb_in    = {32'd0, t_ff} * {32'd0, v_ff[31:0]};
            state_in = S_TDIST;
         end
         S_TDIST: begin
            d_in             = (|prod_sh[85:DW]) ? {DW{1'b1}} : prod_sh[DW-1:0];
            div_req.start    = 1'b1;
            div_req.dividend = {mag_x_ff, 24'd0};
            div_req.divisor  = root_ff[31:0];
            state_in         = S_TDIVX;
         end
         S_TDIVX: begin
            if (div_rsp.done) begin
               rx_in            = div_rsp.quotient[24:0];
               div_req.start    = 1'b1;
               div_req.dividend = {mag_y_ff, 24'd0};
               div_req.divisor  = root_ff[31:0];
               state_in         = S_TDIVY;
            end
         end
         S_TDIVY: begin
            if (div_rsp.done) begin
               ry_in    = div_rsp.quotient[24:0];
               state_in = S_TCMUL;
            end
         end
         S_TCMUL: begin
            res_in.dx   = speed_x_ff[31] ? cx_full[63:32] : (32'd0 - cx_full[63:32]);
            res_in.dy   = speed_y_ff[31] ? cy_full[63:32] : (32'd0 - cy_full[63:32]);
            res_in.step = 1'b1;
            state_in    = S_OUT;
         end
         // hand the result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_in.mode  = mode_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= kdft_pkg::MODE_IDLE;
         press_x_ff    <= '0;
         press_y_ff    <= '0;
         press_time_ff <= '0;
         speed_x_ff    <= '0;
         speed_y_ff    <= '0;
         thr_ff        <= kdft_pkg::TAP_THR_RESET;
         decel_ff      <= kdft_pkg::DECEL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         press_x_ff    <= press_x_in;
         press_y_ff    <= press_y_in;
         press_time_ff <= press_time_in;
         speed_x_ff    <= speed_x_in;
         speed_y_ff    <= speed_y_in;
         thr_ff        <= thr_in;
         decel_ff      <= decel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      t_ff     <= t_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      at_ff    <= at_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      v_ff     <= v_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      d_ff     <= d_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // divider results only arrive while the sequencer waits for one
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_RDIVX || state_ff == S_RDIVY ||
                        state_ff == S_TDIVX || state_ff == S_TDIVY))
      else $error("divider finished outside a wait state");

   // a tap always lands back in idle
   a_tap_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tap) |-> (rsp_ff.mode == kdft_pkg::MODE_IDLE))
      else $error("tap reported outside idle");

   // a gesture start leaves the block dragging or flinging
   a_start_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.gstart) |-> (rsp_ff.mode != kdft_pkg::MODE_IDLE))
      else $error("gesture start with idle mode");

   // a stopped fling is never still flinging
   a_stop_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fstop) |-> (rsp_ff.mode != kdft_pkg::MODE_FLING))
      else $error("fling stop while still flinging");

endmodule

`default_nettype wire
